// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, constants and helpers of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int CHAR_W     = 8;

  // Stream and configuration widths
  localparam int S_TDATA_W  = 32;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Commands
  localparam logic [1:0] CMD_PRINT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_BG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR = 2'd2;

  localparam logic [COLOR_W-1:0] RST_DEF_FG = 4'd15;
  localparam logic [COLOR_W-1:0] RST_DEF_BG = 4'd0;
  localparam logic [COLOR_W-1:0] RST_CURSOR = 4'd7;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PAINT, S_CURSOR, S_SCROLL, S_FILL, S_CLEAR, S_RESULT
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE, RD_CUR, RD_NEW, RD_USER, RD_SCROLL
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_PAINT, WR_CURSOR, WR_BLANK_RST, WR_BLANK, WR_COPY, WR_FILL
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_ZERO, CNT_INC
  } cnt_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD, CUR_ADV, CUR_HOME
  } cur_op_e;

  typedef struct packed {
    logic    lat_in;
    logic    load_res;
    cnt_op_e cnt_op;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    cur_op_e cur_op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       will_scroll;
    logic       cnt_zero;
    logic       cnt_last;
    logic       cnt_copy_end;
    logic       out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] cell_idx(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    cell_idx = ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

  function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg);
    blank_cell = {bg, fg, CH_NUL};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_valid_i,
  output logic       s_ready_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    s_ready_o      = 1'b0;
    ctrl_o.lat_in   = 1'b0;
    ctrl_o.load_res = 1'b0;
    ctrl_o.cnt_op   = CNT_HOLD;
    ctrl_o.rd_sel   = RD_NONE;
    ctrl_o.wr_sel   = WR_NONE;
    ctrl_o.cur_op   = CUR_HOLD;
    case (state_q)
      S_INIT: begin
        ctrl_o.wr_sel = WR_BLANK_RST;
        ctrl_o.cnt_op = CNT_INC;
        if (stat_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.lat_in = 1'b1;
          ctrl_o.cnt_op = CNT_ZERO;
          case (stat_i.in_cmd)
            CMD_PRINT: begin
              ctrl_o.rd_sel = RD_CUR;
              state_d       = S_PAINT;
            end
            CMD_READ: begin
              ctrl_o.rd_sel = RD_USER;
              state_d       = S_RESULT;
            end
            CMD_CLEAR: begin
              ctrl_o.cur_op = CUR_HOME;
              state_d       = S_CLEAR;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_PAINT: begin
        ctrl_o.wr_sel = WR_PAINT;
        ctrl_o.cur_op = CUR_ADV;
        if (stat_i.will_scroll) begin
          state_d = S_SCROLL;
        end else begin
          ctrl_o.rd_sel = RD_NEW;
          state_d       = S_CURSOR;
        end
      end
      S_CURSOR: begin
        ctrl_o.wr_sel = WR_CURSOR;
        state_d       = S_RESULT;
      end
      S_SCROLL: begin
        // read one row ahead, write the word read last cycle
        if (!stat_i.cnt_zero) ctrl_o.wr_sel = WR_COPY;
        if (stat_i.cnt_copy_end) begin
          state_d = S_FILL;
        end else begin
          ctrl_o.rd_sel = RD_SCROLL;
          ctrl_o.cnt_op = CNT_INC;
        end
      end
      S_FILL: begin
        ctrl_o.wr_sel = WR_FILL;
        ctrl_o.cnt_op = CNT_INC;
        if (stat_i.cnt_last) state_d = S_RESULT;
      end
      S_CLEAR: begin
        ctrl_o.wr_sel = WR_BLANK;
        ctrl_o.cnt_op = CNT_INC;
        if (stat_i.cnt_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          ctrl_o.load_res = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_dp.sv =====
// Datapath of the text console writer: screen memory, cursor, registers, result.
`default_nettype none

module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_t                 ctrl_i,
  output stat_t                      stat_o,
  input  wire logic [S_TDATA_W-1:0]  s_data_i,
  input  wire logic [S_TUSER_W-1:0]  s_user_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [M_TDATA_W-1:0]       m_data_o
);

  // Request fields
  logic [CHAR_W-1:0]  in_char;
  logic [COLOR_W-1:0] in_fg, in_bg;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;

  assign in_char = s_data_i[7:0];
  assign in_fg   = s_data_i[11:8];
  assign in_bg   = s_data_i[15:12];
  assign in_row  = s_data_i[20:16];
  assign in_col  = s_data_i[27:21];

  // Configuration registers
  logic [COLOR_W-1:0] def_fg_q, def_bg_q, cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_fg_q <= RST_DEF_FG;
      def_bg_q <= RST_DEF_BG;
      cursor_q <= RST_CURSOR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEF_FG: def_fg_q <= cfg_data_i;
        CFG_DEF_BG: def_bg_q <= cfg_data_i;
        CFG_CURSOR: cursor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched request
  logic [1:0]         cmd_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lat_in) begin
      cmd_q   <= s_user_i;
      ch_q    <= in_char;
      fg_q    <= in_fg;
      bg_q    <= in_bg;
      rd_ok_q <= (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);
    end
  end

  // Cursor and next position
  logic [ROW_W-1:0] cur_row_q, nxt_row;
  logic [COL_W-1:0] cur_col_q, nxt_col;
  logic             wrap, will_scroll;
  logic [COL_W:0]   col_inc, col_tab;
  logic [ROW_W:0]   row_inc;

  assign col_inc = {1'b0, cur_col_q} + (COL_W+1)'(1);
  assign col_tab = {1'b0, cur_col_q[COL_W-1:2], 2'b00} + (COL_W+1)'(4);
  assign row_inc = {1'b0, cur_row_q} + (ROW_W+1)'(1);

  always_comb begin
    wrap    = 1'b0;
    nxt_col = col_inc[COL_W-1:0];
    case (ch_q)
      CH_TAB: begin
        if (col_tab >= (COL_W+1)'(COLUMNS)) begin
          nxt_col = COL_W'(col_tab - (COL_W+1)'(COLUMNS));
          wrap    = 1'b1;
        end else begin
          nxt_col = col_tab[COL_W-1:0];
        end
      end
      CH_NL: begin
        nxt_col = '0;
        wrap    = 1'b1;
      end
      default: begin
        if (col_inc >= (COL_W+1)'(COLUMNS)) begin
          nxt_col = '0;
          wrap    = 1'b1;
        end
      end
    endcase
    will_scroll = wrap && (row_inc >= (ROW_W+1)'(ROWS));
    if (will_scroll)  nxt_row = ROW_W'(ROWS - 1);
    else if (wrap)    nxt_row = row_inc[ROW_W-1:0];
    else              nxt_row = cur_row_q;
  end

  logic scrolled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (ctrl_i.lat_in) scrolled_q <= 1'b0;
      case (ctrl_i.cur_op)
        CUR_ADV: begin
          cur_row_q  <= nxt_row;
          cur_col_q  <= nxt_col;
          scrolled_q <= will_scroll;
        end
        CUR_HOME: begin
          cur_row_q <= '0;
          cur_col_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Sweep counter for the reset sweep, clear, scroll and fill
  logic [ADDR_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (ctrl_i.cnt_op)
        CNT_ZERO: cnt_q <= '0;
        CNT_INC:  cnt_q <= cnt_q + ADDR_W'(1);
        default:  cnt_q <= cnt_q;
      endcase
    end
  end

  // Screen memory
  logic [CELL_W-1:0] mem_q [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q, wr_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr, cur_idx;
  logic              store_ch;

  assign cur_idx  = cell_idx(cur_row_q, cur_col_q);
  assign store_ch = (ch_q != CH_TAB) && (ch_q != CH_NL) &&
                    (ch_q != CH_SPACE) && (ch_q != CH_BS);

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_NEW:    rd_addr = cell_idx(nxt_row, nxt_col);
      RD_USER:   rd_addr = cell_idx(in_row, in_col);
      RD_SCROLL: rd_addr = cnt_q + ADDR_W'(COLUMNS);
      default:   rd_addr = cur_idx;
    endcase
  end

  always_comb begin
    wr_addr = cnt_q;
    wr_data = blank_cell(def_fg_q, def_bg_q);
    case (ctrl_i.wr_sel)
      WR_PAINT: begin
        wr_addr = cur_idx;
        wr_data = {bg_q, fg_q, (store_ch ? ch_q : rd_data_q[CHAR_W-1:0])};
      end
      WR_CURSOR: begin
        wr_addr = cur_idx;
        wr_data = {cursor_q, rd_data_q[CELL_W-COLOR_W-1:0]};
      end
      WR_BLANK_RST: wr_data = blank_cell(RST_DEF_FG, RST_DEF_BG);
      WR_COPY: begin
        wr_addr = cnt_q - ADDR_W'(1);
        wr_data = rd_data_q;
      end
      WR_FILL: begin
        // new cursor cell on the fresh bottom row
        if (cnt_q == cur_idx) wr_data = blank_cell(def_fg_q, cursor_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_sel != WR_NONE) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_sel != RD_NONE) rd_data_q <= mem_q[rd_addr];
  end

  // Result register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [CELL_W-1:0]    res_cell;

  assign res_cell = (cmd_q == CMD_READ && rd_ok_q) ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_res) begin
      out_data_q <= {3'b000, res_cell[15:12], res_cell[11:8], res_cell[7:0],
                     scrolled_q, cur_col_q, cur_row_q};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  assign stat_o.in_cmd       = s_user_i;
  assign stat_o.will_scroll  = will_scroll;
  assign stat_o.cnt_zero     = (cnt_q == '0);
  assign stat_o.cnt_last     = (cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign stat_o.cnt_copy_end = (cnt_q == ADDR_W'(CELL_COUNT - COLUMNS));
  assign stat_o.out_free     = !out_valid_q || m_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer.
//
//   port group   dir  payload
//   s_axis       in   tuser: cmd[1:0]; tdata: character, foreground, background,
//                     read_row, read_col
//   m_axis       out  tdata: cursor_row, cursor_col, scrolled, cell_char,
//                     cell_foreground, cell_background
//   cfg          in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A print paints its cell and then the cursor cell; a read looks up one cell.
// A print that scrolls and a clear sweep the screen through the single write
// port of the screen memory, which moves one cell per cycle. After reset the
// screen memory is swept in full with tready low. A result waits in the output
// register while m_axis_tready is low; the next request is taken meanwhile.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] character, [11:8] foreground, [15:12] background,
  // [20:16] read_row, [27:21] read_col
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [4:0] cursor_row, [11:5] cursor_col, [12] scrolled, [20:13] cell_char,
  // [24:21] cell_foreground, [28:25] cell_background
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  tcw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_chk.sv =====
// Port checker of the text console writer and its bind.
`default_nettype none

module tcw_chk
  import tcw_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  // one request at a time: the port closes after each accepted request
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[4:0]) < ROWS) &&
                      (int'(m_axis_tdata[11:5]) < COLUMNS))
    else $error("cursor off screen");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> int'(m_axis_tdata[4:0]) == ROWS - 1)
    else $error("scroll left cursor off last row");

endmodule

bind text_console_writer tcw_chk u_chk (.*);

`default_nettype wire

// ===== dv/text_console_writer_test.sv =====
// Self-checking stream testbench of the text console writer, with a shadow screen and random idling.
module text_console_writer_test;
  import tcw_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } con_req_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic       scrolled;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } con_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow of the screen, cursor and color registers
  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       crow, ccol;
  logic [3:0]        dflt_fg, dflt_bg, cursor_bg;

  con_req_t    queued_cmds [$];
  con_rsp_t    expected_replies [$];
  con_req_t    offered;
  int unsigned cmds_issued = 0;
  int unsigned cmds_taken = 0;
  int unsigned real_cmds = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        src_quiet = 1'b0;
  logic        sink_quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned holds_done = 0;

  text_console_writer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = {dflt_bg, dflt_fg, CH_NUL};
    crow = 0;
    ccol = 0;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
      shadow_screen[i] = {dflt_bg, dflt_fg, CH_NUL};
  endfunction

  function automatic con_rsp_t apply_console_cmd(input con_req_t r);
    con_rsp_t    o;
    int unsigned row, col, at;
    logic [15:0] c;
    o = '0;
    case (r.cmd)
      CMD_PRINT: begin
        row = crow;
        col = ccol;
        at  = row * COLUMNS + col;
        c   = {r.bg, r.fg, shadow_screen[at][7:0]};
        if (r.ch == CH_TAB) begin
          col = (col & ~32'd3) + 4;
          if (col >= COLUMNS) begin
            col = col - COLUMNS;
            row++;
          end
        end else if (r.ch == CH_NL) begin
          col = 0;
          row++;
        end else begin
          // space and backspace keep the old character but take the new colors
          if (r.ch != CH_SPACE && r.ch != CH_BS) c[7:0] = r.ch;
          col++;
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
        end
        shadow_screen[at] = c;
        if (row >= ROWS) begin
          scroll_screen();
          row = ROWS - 1;
          o.scrolled = 1'b1;
        end
        crow = row;
        ccol = col;
        shadow_screen[row * COLUMNS + col][15:12] = cursor_bg;
      end
      CMD_READ: begin
        if (r.rrow < ROWS && r.rcol < COLUMNS) begin
          c    = shadow_screen[r.rrow * COLUMNS + r.rcol];
          o.ch = c[7:0];
          o.fg = c[11:8];
          o.bg = c[15:12];
        end
      end
      CMD_CLEAR: blank_screen();
      default: ;
    endcase
    o.row = 5'(crow);
    o.col = 7'(ccol);
    return o;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    fail_count++;
  endtask

  task automatic check_reply(input logic [M_TDATA_W-1:0] d);
    con_rsp_t want;
    if (expected_replies.size() == 0) begin
      report("result with no request pending", d, 0);
      return;
    end
    want = expected_replies.pop_front();
    if (d[4:0] != want.row)      report("cursor_row", d[4:0], want.row);
    if (d[11:5] != want.col)     report("cursor_col", d[11:5], want.col);
    if (d[12] != want.scrolled)  report("scrolled", d[12], want.scrolled);
    if (d[20:13] != want.ch)     report("cell_char", d[20:13], want.ch);
    if (d[24:21] != want.fg)     report("cell_foreground", d[24:21], want.fg);
    if (d[28:25] != want.bg)     report("cell_background", d[28:25], want.bg);
  endtask

  // request source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap       <= 0;
    end else begin
      if ($urandom_range(0, 149) == 0) src_quiet <= !src_quiet;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_console_cmd(offered));
        cmds_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          offered = queued_cmds.pop_front();
          s_axis_tdata  <= {4'b0, offered.rcol, offered.rrow, offered.bg, offered.fg, offered.ch};
          s_axis_tuser  <= offered.cmd;
          s_axis_tvalid <= 1'b1;
          src_gap       <= src_quiet ? 0 : idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
    end else begin
      if ($urandom_range(0, 149) == 0) sink_quiet <= !sink_quiet;
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      if (hold_req != holds_done) begin
        // hold off long enough to back up the request side
        holds_done    <= holds_done + 1;
        sink_gap      <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap      <= sink_quiet ? 0 : idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic con_req_t mk(input logic [1:0] cmd, input logic [7:0] ch,
                                  input logic [3:0] fg, input logic [3:0] bg,
                                  input logic [4:0] rrow, input logic [6:0] rcol);
    con_req_t r;
    r = '{cmd: cmd, ch: ch, fg: fg, bg: bg, rrow: rrow, rcol: rcol};
    return r;
  endfunction

  function automatic con_req_t any_req(input logic [1:0] cmd);
    return mk(cmd, 8'($urandom()), 4'($urandom()), 4'($urandom()), 5'($urandom()),
              7'($urandom()));
  endfunction

  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return CH_TAB;
    if (r == 1) return CH_SPACE;
    if (r == 2) return CH_BS;
    if (r == 3) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  task automatic push_cmd(input con_req_t r);
    queued_cmds.push_back(r);
    cmds_issued++;
    if (r.cmd != CMD_UNUSED) real_cmds++;
  endtask

  task automatic push_print(input logic [7:0] ch);
    con_req_t r;
    r    = any_req(CMD_PRINT);
    r.ch = ch;
    push_cmd(r);
  endtask

  task automatic add_random_items(input int unsigned target);
    int unsigned stop, kind, len;
    con_req_t    r;
    stop = real_cmds + target;
    while (real_cmds < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // a line of text, now and then long enough to wrap
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
        repeat (len) push_print(text_byte());
        if ($urandom_range(0, 3) != 0) push_print(CH_NL);
      end else if (kind < 58) begin
        repeat ($urandom_range(2, 26)) push_print(CH_NL);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 8)) begin
          r = any_req(CMD_READ);
          if ($urandom_range(0, 9) != 0) begin
            r.rrow = 5'($urandom_range(0, ROWS - 1));
            r.rcol = 7'($urandom_range(0, COLUMNS - 1));
          end
          push_cmd(r);
        end
      end else if (kind < 83) begin
        push_cmd(any_req(CMD_CLEAR));
      end else if (kind < 90) begin
        push_cmd(any_req(CMD_UNUSED));
      end else begin
        push_cmd(any_req(2'($urandom_range(0, 2))));
      end
    end
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg, input logic [3:0] cur);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEF_FG;
    cfg_data_i <= fg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DEF_BG;
    cfg_data_i <= bg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CURSOR;
    cfg_data_i <= cur;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dflt_fg   = fg;
    dflt_bg   = bg;
    cursor_bg = cur;
  endtask

  task automatic wait_idle();
    while (cmds_taken != cmds_issued || expected_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph;
    logic [3:0]  pf, pb, pc;
    dflt_fg   = RST_DEF_FG;
    dflt_bg   = RST_DEF_BG;
    cursor_bg = RST_CURSOR;
    blank_screen();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, "A", 4'h0, 4'hf, 5'h1f, 7'h7f));
    push_cmd(mk(CMD_READ, 8'hff, 4'hf, 4'hf, 5'd0, 7'd0));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));
    push_cmd(mk(CMD_PRINT, CH_NUL, 4'hf, 4'hf, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, 8'hff, 4'h0, 4'h0, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, CH_TAB, 4'h3, 4'hc, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, CH_SPACE, 4'h5, 4'ha, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, CH_BS, 4'ha, 4'h5, 5'd0, 7'd0));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd4));
    push_cmd(mk(CMD_PRINT, CH_NL, 4'h1, 4'h2, 5'd0, 7'd0));
    // reads at and beyond the screen edges; those outside return empty cell fields
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'h1f, 7'h7f));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd79));
    // unused command only echoes the cursor
    push_cmd(mk(CMD_UNUSED, 8'hff, 4'hf, 4'hf, 5'h1f, 7'h7f));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
    // clear homes the cursor without painting it
    push_cmd(mk(CMD_CLEAR, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
    push_cmd(mk(CMD_PRINT, "z", 4'h9, 4'h6, 5'd0, 7'd0));
    push_cmd(mk(CMD_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));

    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin pf = 4'h0; pb = 4'hf; pc = 4'h0; end
        1: begin pf = 4'hf; pb = 4'hf; pc = 4'hf; end
        3: begin pf = 4'h0; pb = 4'h0; pc = 4'hf; end
        default: begin
          pf = 4'($urandom_range(0, 15));
          pb = 4'($urandom_range(0, 15));
          pc = 4'($urandom_range(0, 15));
        end
      endcase
      set_colors(pf, pb, pc);
      if (ph == 2) hold_req <= hold_req + 1;
      add_random_items(150);
    end

    wait_idle();
    // drain window covers a full scroll
    repeat (CELL_COUNT + 100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
